// File: hw/rtl/rsi_pkg.sv
// rsi_pkg: widths, latencies and shared types of the ray-sphere intersection pipeline
// no dependencies
package rsi_pkg;

	localparam int COORD_W  = 32;
	localparam int RADIN_W  = 31;
	localparam int OC_W     = 33;
	localparam int H_W      = 67;
	localparam int A_W      = 64;
	localparam int C_W      = 67;
	localparam int MUL_W    = 68;
	localparam int D_W      = 2 * MUL_W;
	localparam int SQ_IN_W  = 128;
	localparam int ROOT_W   = SQ_IN_W / 2;
	localparam int NUM_W    = 68;
	localparam int Q_W      = 33;
	localparam int MUL_LAT  = 3;
	localparam int SQRT_LAT = ROOT_W;
	localparam int DIV_LAT  = Q_W + 2;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic   miss;
		coord_t lo;
		coord_t hi;
	} ctl_t;

endpackage

// File: hw/rtl/rsi_mul.sv
// rsi_mul: three-stage signed multiplier built from four half-width partial products
// no dependencies
module rsi_mul #(
	parameter int W = 68
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);

	localparam int LO_W = W / 2;
	localparam int HI_W = W - LO_W;

	logic signed [HI_W-1:0]      a_hi, b_hi;
	logic signed [LO_W:0]        a_lo, b_lo;
	logic signed [2*LO_W+1:0]    ll_s1, ll_s2;
	logic signed [HI_W+LO_W:0]   hl_s1, lh_s1;
	logic signed [2*HI_W-1:0]    hh_s1, hh_s2;
	logic signed [HI_W+LO_W+1:0] mid_s2;

	assign a_hi = a[W-1:LO_W];
	assign b_hi = b[W-1:LO_W];
	assign a_lo = {1'b0, a[LO_W-1:0]};
	assign b_lo = {1'b0, b[LO_W-1:0]};

	always_ff @(posedge clk) begin
		ll_s1 <= a_lo * b_lo;
		hl_s1 <= a_hi * b_lo;
		lh_s1 <= a_lo * b_hi;
		hh_s1 <= a_hi * b_hi;
	end

	always_ff @(posedge clk) begin
		mid_s2 <= (HI_W+LO_W+2)'(hl_s1) + (HI_W+LO_W+2)'(lh_s1);
		ll_s2  <= ll_s1;
		hh_s2  <= hh_s1;
	end

	always_ff @(posedge clk) begin
		p <= ((2*W)'(hh_s2) <<< (2*LO_W)) + ((2*W)'(mid_s2) <<< LO_W) + (2*W)'(ll_s2);
	end

endmodule

// File: hw/rtl/rsi_sqrt.sv
// rsi_sqrt: pipelined integer square root, one result bit per stage, rounded down
// no dependencies
module rsi_sqrt #(
	parameter int IN_W = 128
) (
	input  logic              clk,
	input  logic [IN_W-1:0]   rad,
	output logic [IN_W/2-1:0] root
);

	localparam int N   = IN_W / 2;
	localparam int R_W = N + 2;

	logic [R_W-1:0]  rem_s  [N];
	logic [N-1:0]    root_s [N];
	logic [IN_W-1:0] rad_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [R_W-1:0]  rem_p, cur, trial;
		logic [N-1:0]    root_p;
		logic [IN_W-1:0] rad_p;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p  = rad_s[k-1];
		end

		assign cur   = {rem_p[R_W-3:0], rad_p[IN_W-1 -: 2]};
		assign trial = {root_p, 2'b01};

		always_ff @(posedge clk) begin
			if (cur >= trial) begin
				rem_s[k]  <= cur - trial;
				root_s[k] <= {root_p[N-2:0], 1'b1};
			end else begin
				rem_s[k]  <= cur;
				root_s[k] <= {root_p[N-2:0], 1'b0};
			end
		end

		if (k < N - 1) begin : g_shift
			always_ff @(posedge clk) begin
				rad_s[k] <= {rad_p[IN_W-3:0], 2'b00};
			end
		end else begin : g_tail
			assign rad_s[k] = '0;
		end
	end

	assign root = root_s[N-1];

endmodule

// File: hw/rtl/rsi_div.sv
// rsi_div: pipelined restoring divider, floor(num * 2^F / den) saturated to 32 bits
// depends on rsi_pkg
module rsi_div import rsi_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic signed [NUM_W-1:0] num,
	input  logic        [A_W-1:0]   den,
	output coord_t                  t
);

	localparam int MAG_W  = NUM_W + FRAC_BITS;
	localparam int HIGH_W = MAG_W - Q_W;
	localparam int CMP_W  = (HIGH_W > A_W) ? HIGH_W : A_W;
	localparam logic [Q_W:0] NEG_LIM = (Q_W+1)'(1) << (COORD_W - 1);
	localparam logic [Q_W:0] POS_LIM = NEG_LIM - (Q_W+1)'(1);

	logic [NUM_W-1:0] num_abs;
	logic [MAG_W-1:0] mag;
	logic [CMP_W-1:0] high, den_x;

	logic           neg_s1, big_s1;
	logic [A_W-1:0] rem_s1, den_s1;
	logic [Q_W-1:0] low_s1;

	logic           neg_s [Q_W];
	logic           big_s [Q_W];
	logic [A_W-1:0] rem_s [Q_W];
	logic [A_W-1:0] den_s [Q_W];
	logic [Q_W-1:0] low_s [Q_W];
	logic [Q_W-1:0] q_s   [Q_W];

	logic [Q_W:0] m, m_neg, q_x;

	assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign mag     = {num_abs, {FRAC_BITS{1'b0}}};
	assign high    = CMP_W'(mag[MAG_W-1:Q_W]);
	assign den_x   = CMP_W'(den);

	always_ff @(posedge clk) begin
		neg_s1 <= num[NUM_W-1];
		big_s1 <= high >= den_x;
		rem_s1 <= high[A_W-1:0];
		low_s1 <= mag[Q_W-1:0];
		den_s1 <= den;
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic           neg_p, big_p, ge;
		logic [A_W-1:0] rem_p, den_p;
		logic [Q_W-1:0] low_p, q_p;
		logic [A_W:0]   cur, diff;

		if (k == 0) begin : g_first
			assign neg_p = neg_s1;
			assign big_p = big_s1;
			assign rem_p = rem_s1;
			assign den_p = den_s1;
			assign low_p = low_s1;
			assign q_p   = '0;
		end else begin : g_next
			assign neg_p = neg_s[k-1];
			assign big_p = big_s[k-1];
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign low_p = low_s[k-1];
			assign q_p   = q_s[k-1];
		end

		assign cur  = {rem_p, low_p[Q_W-1]};
		assign diff = cur - {1'b0, den_p};
		assign ge   = cur >= {1'b0, den_p};

		always_ff @(posedge clk) begin
			neg_s[k] <= neg_p;
			big_s[k] <= big_p;
			rem_s[k] <= ge ? diff[A_W-1:0] : cur[A_W-1:0];
			q_s[k]   <= {q_p[Q_W-2:0], ge};
		end

		if (k < Q_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				den_s[k] <= den_p;
				low_s[k] <= {low_p[Q_W-2:0], 1'b0};
			end
		end else begin : g_tail
			assign den_s[k] = '0;
			assign low_s[k] = '0;
		end
	end

	assign q_x   = {1'b0, q_s[Q_W-1]};
	assign m     = q_x + (Q_W+1)'(rem_s[Q_W-1] != '0);
	assign m_neg = (Q_W+1)'(0) - m;

	always_ff @(posedge clk) begin
		if (neg_s[Q_W-1]) begin
			if (big_s[Q_W-1] || m > NEG_LIM)
				t <= {1'b1, {(COORD_W-1){1'b0}}};
			else
				t <= m_neg[COORD_W-1:0];
		end else begin
			if (big_s[Q_W-1] || q_x > POS_LIM)
				t <= {1'b0, {(COORD_W-1){1'b1}}};
			else
				t <= q_x[COORD_W-1:0];
		end
	end

endmodule

// File: hw/rtl/ray_sphere_intersection.sv
// ray_sphere_intersection: fully pipelined fixed-point ray-sphere hit test
// depends on rsi_pkg, rsi_mul, rsi_sqrt, rsi_div
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  command  | start, busy          | origin, direction, centre, radius, interval
//  result   | done (one-cycle)     | hit, hit_distance
//
// one word accepted every cycle; busy is always low
// an accepted word passes the input, product and sum registers, the multipliers,
// the square-root input register, the 64-stage square root, the numerator
// register, the 35-stage dividers and the result register before done rises
// reset clears only the valid line; results cannot be held off
module ray_sphere_intersection import rsi_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  coord_t               origin_x,
	input  coord_t               origin_y,
	input  coord_t               origin_z,
	input  coord_t               direction_x,
	input  coord_t               direction_y,
	input  coord_t               direction_z,
	input  coord_t               center_x,
	input  coord_t               center_y,
	input  coord_t               center_z,
	input  logic [RADIN_W-1:0]   sphere_radius,
	input  coord_t               interval_low,
	input  coord_t               interval_high,
	output logic                 done,
	output logic                 hit,
	output coord_t               hit_distance
);

	localparam int N_HA  = MUL_LAT + 1 + SQRT_LAT;
	localparam int N_CTL = N_HA + 1 + DIV_LAT;
	localparam int LAT   = N_CTL + 4;

	coord_t o_in [3];
	coord_t c_in [3];
	coord_t d_in [3];

	logic                     valid_s1, valid_s2, valid_s3;
	logic signed [OC_W-1:0]   oc_s1 [3];
	coord_t                   d_s1  [3];
	logic [RADIN_W-1:0]       r_s1;
	ctl_t                     ctl_s1, ctl_s2, ctl_s3;

	logic signed [OC_W+COORD_W-1:0] ocd_s2 [3];
	logic signed [2*COORD_W-1:0]    dd_s2  [3];
	logic signed [2*OC_W-1:0]       occ_s2 [3];
	logic [2*RADIN_W-1:0]           rsq_s2;

	logic signed [H_W-1:0] h_s3;
	logic [A_W-1:0]        a_s3;
	logic signed [C_W-1:0] c_s3;

	logic signed [D_W-1:0] hh_p, ac_p, d_c;
	logic [SQ_IN_W-1:0]    sq_in_s4;
	logic [ROOT_W-1:0]     root;

	logic signed [H_W-1:0] h_dl [N_HA];
	logic [A_W-1:0]        a_dl [N_HA];

	logic signed [NUM_W-1:0] num0_s5, num1_s5, h_x;
	logic [A_W-1:0]          den_s5;
	coord_t                  t0, t1;

	ctl_t               ctl_dl [N_CTL];
	logic [N_CTL-1:0]   vld_dl;
	ctl_t               ctl_f;
	logic               in0, in1;
	logic               done_q, hit_q;
	coord_t             dist_q;

	assign busy = 1'b0;

	assign o_in = '{origin_x, origin_y, origin_z};
	assign c_in = '{center_x, center_y, center_z};
	assign d_in = '{direction_x, direction_y, direction_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			vld_dl   <= '0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			vld_dl   <= {vld_dl[N_CTL-2:0], valid_s3};
			done_q   <= vld_dl[N_CTL-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			oc_s1[i] <= OC_W'(o_in[i]) - OC_W'(c_in[i]);
			d_s1[i]  <= d_in[i];
		end
		r_s1   <= sphere_radius;
		ctl_s1 <= '{miss: 1'b0, lo: interval_low, hi: interval_high};
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ocd_s2[i] <= oc_s1[i] * d_s1[i];
			dd_s2[i]  <= d_s1[i] * d_s1[i];
			occ_s2[i] <= oc_s1[i] * oc_s1[i];
		end
		rsq_s2 <= r_s1 * r_s1;
		ctl_s2 <= '{miss: (d_s1[0] == '0) && (d_s1[1] == '0) && (d_s1[2] == '0),
		            lo: ctl_s1.lo, hi: ctl_s1.hi};
	end

	always_ff @(posedge clk) begin
		h_s3   <= H_W'(ocd_s2[0]) + H_W'(ocd_s2[1]) + H_W'(ocd_s2[2]);
		a_s3   <= A_W'(dd_s2[0]) + A_W'(dd_s2[1]) + A_W'(dd_s2[2]);
		c_s3   <= C_W'(occ_s2[0]) + C_W'(occ_s2[1]) + C_W'(occ_s2[2])
		          - C_W'($signed({1'b0, rsq_s2}));
		ctl_s3 <= ctl_s2;
	end

	// discriminant h*h - a*c
	rsi_mul #(.W(MUL_W)) u_mul_hh (
		.clk (clk),
		.a   (MUL_W'(h_s3)),
		.b   (MUL_W'(h_s3)),
		.p   (hh_p)
	);

	rsi_mul #(.W(MUL_W)) u_mul_ac (
		.clk (clk),
		.a   ($signed(MUL_W'(a_s3))),
		.b   (MUL_W'(c_s3)),
		.p   (ac_p)
	);

	assign d_c = hh_p - ac_p;

	always_ff @(posedge clk) begin
		sq_in_s4 <= d_c[SQ_IN_W-1:0];
	end

	rsi_sqrt #(.IN_W(SQ_IN_W)) u_sqrt (
		.clk  (clk),
		.rad  (sq_in_s4),
		.root (root)
	);

	always_ff @(posedge clk) begin
		h_dl[0] <= h_s3;
		a_dl[0] <= a_s3;
		for (int i = 1; i < N_HA; i++) begin
			h_dl[i] <= h_dl[i-1];
			a_dl[i] <= a_dl[i-1];
		end
	end

	assign h_x = NUM_W'(h_dl[N_HA-1]);

	always_ff @(posedge clk) begin
		num0_s5 <= -h_x - $signed(NUM_W'(root));
		num1_s5 <= -h_x + $signed(NUM_W'(root));
		den_s5  <= a_dl[N_HA-1];
	end

	rsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_near (
		.clk (clk),
		.num (num0_s5),
		.den (den_s5),
		.t   (t0)
	);

	rsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_far (
		.clk (clk),
		.num (num1_s5),
		.den (den_s5),
		.t   (t1)
	);

	// negative discriminant joins the miss flag where the products land
	always_ff @(posedge clk) begin
		ctl_dl[0] <= ctl_s3;
		for (int i = 1; i < N_CTL; i++) begin
			if (i == MUL_LAT)
				ctl_dl[i] <= '{miss: ctl_dl[i-1].miss | d_c[D_W-1],
				               lo: ctl_dl[i-1].lo, hi: ctl_dl[i-1].hi};
			else
				ctl_dl[i] <= ctl_dl[i-1];
		end
	end

	assign ctl_f = ctl_dl[N_CTL-1];
	assign in0   = !ctl_f.miss && (t0 > ctl_f.lo) && (t0 < ctl_f.hi);
	assign in1   = !ctl_f.miss && (t1 > ctl_f.lo) && (t1 < ctl_f.hi);

	always_ff @(posedge clk) begin
		hit_q <= in0 || in1;
		if (in0)
			dist_q <= t0;
		else if (in1)
			dist_q <= t1;
		else
			dist_q <= '0;
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign hit_distance = dist_q;

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> hit_distance == '0)
		else $error("miss word with non-zero distance");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted word did not emerge");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result word without a command");

	a_no_sat_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> hit_distance != {1'b1, {(COORD_W-1){1'b0}}}
		&& hit_distance != {1'b0, {(COORD_W-1){1'b1}}})
		else $error("saturated distance reported as hit");
`endif

endmodule

// File: tb/ray_sphere_intersection_checker.sv
// ray_sphere_intersection_checker: predicts the hit result of every accepted command word
// and compares it with each done word; depends on rsi_pkg
`timescale 1ns / 100ps
module ray_sphere_intersection_checker import rsi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  coord_t               origin_x,
	input  coord_t               origin_y,
	input  coord_t               origin_z,
	input  coord_t               direction_x,
	input  coord_t               direction_y,
	input  coord_t               direction_z,
	input  coord_t               center_x,
	input  coord_t               center_y,
	input  coord_t               center_z,
	input  logic [RADIN_W-1:0]   sphere_radius,
	input  coord_t               interval_low,
	input  coord_t               interval_high,
	input  logic                 done,
	input  logic                 hit,
	input  coord_t               hit_distance,
	output int                   errors,
	output int                   pending
);
	localparam int FB = 16;

	typedef struct packed {
		logic   hit;
		coord_t distance;
	} hit_word_t;

	hit_word_t hit_queue[$];

	function automatic logic signed [255:0] floor_div(logic signed [255:0] num,
			logic signed [255:0] den);
		logic signed [255:0] q;
		q = num / den;
		if ((num % den != 0) && (num < 0))
			q = q - 1;
		return q;
	endfunction

	function automatic logic signed [255:0] int_sqrt(logic signed [255:0] n);
		logic signed [255:0] res;
		logic signed [255:0] bitv;
		res = 0;
		bitv = 256'sd1 <<< 252;
		while (bitv > n)
			bitv = bitv >>> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >>> 1) + bitv;
			end else begin
				res = res >>> 1;
			end
			bitv = bitv >>> 2;
		end
		return res;
	endfunction

	function automatic logic signed [255:0] to_dist(logic signed [255:0] num,
			logic signed [255:0] den);
		logic signed [255:0] t;
		t = floor_div(num <<< FB, den);
		if (t > 256'sd2147483647)
			t = 256'sd2147483647;
		if (t < -256'sd2147483648)
			t = -256'sd2147483648;
		return t;
	endfunction

	function automatic hit_word_t predict_hit(coord_t ox, coord_t oy, coord_t oz,
			coord_t dx, coord_t dy, coord_t dz, coord_t cx, coord_t cy, coord_t cz,
			logic [RADIN_W-1:0] rad, coord_t lo, coord_t hi);
		logic signed [255:0] ocx, ocy, ocz, vx, vy, vz, h, a, c, disc, s, t;
		hit_word_t w;
		w = '0;
		ocx = 256'(ox) - 256'(cx);
		ocy = 256'(oy) - 256'(cy);
		ocz = 256'(oz) - 256'(cz);
		vx = 256'(dx);
		vy = 256'(dy);
		vz = 256'(dz);
		h = ocx * vx + ocy * vy + ocz * vz;
		a = vx * vx + vy * vy + vz * vz;
		c = ocx * ocx + ocy * ocy + ocz * ocz - $signed({225'd0, rad}) * $signed({225'd0, rad});
		if (a == 0)
			return w;
		disc = h * h - a * c;
		if (disc < 0)
			return w;
		s = int_sqrt(disc);
		t = to_dist(-h - s, a);
		if (t > 256'(lo) && t < 256'(hi)) begin
			w.hit = 1'b1;
			w.distance = coord_t'(t);
			return w;
		end
		t = to_dist(-h + s, a);
		if (t > 256'(lo) && t < 256'(hi)) begin
			w.hit = 1'b1;
			w.distance = coord_t'(t);
		end
		return w;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	assign pending = hit_queue.size();

	initial errors = 0;

	always @(posedge clk) begin
		hit_word_t want;
		if (arst_n) begin
			if (start && !busy)
				hit_queue.push_back(predict_hit(origin_x, origin_y, origin_z, direction_x,
					direction_y, direction_z, center_x, center_y, center_z, sphere_radius,
					interval_low, interval_high));
			if (done) begin
				if (hit_queue.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = hit_queue.pop_front();
					if (hit !== want.hit)
						report_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
					if (hit_distance !== want.distance)
						report_mismatch($sformatf("hit_distance %0d, expected %0d",
							hit_distance, want.distance));
				end
			end
		end
	end

endmodule

// File: tb/ray_sphere_intersection_tb.sv
// ray_sphere_intersection_tb: directed and random command words into the hit-test pipeline
// depends on rsi_pkg, ray_sphere_intersection and ray_sphere_intersection_checker
`timescale 1ns / 100ps
module ray_sphere_intersection_tb;
	import rsi_pkg::*;

	localparam int N_RANDOM  = 900;
	localparam int LATENCY   = 107;
	localparam int IDLE_LIMIT = 2000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	coord_t             origin_x, origin_y, origin_z;
	coord_t             direction_x, direction_y, direction_z;
	coord_t             center_x, center_y, center_z;
	logic [RADIN_W-1:0] sphere_radius;
	coord_t             interval_low, interval_high;
	logic               done;
	logic               hit;
	coord_t             hit_distance;
	int                 errors;
	int                 pending;
	int                 quiet_cycles;

	ray_sphere_intersection dut (.*);

	ray_sphere_intersection_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog: cycles without any accepted word or result word
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic coord_t rand_word();
		return coord_t'($urandom);
	endfunction

	function automatic coord_t rand_small(int span);
		return coord_t'(int'($urandom_range(2 * span)) - span) <<< 16;
	endfunction

	task automatic send_word(coord_t ox, coord_t oy, coord_t oz, coord_t dx, coord_t dy,
			coord_t dz, coord_t cx, coord_t cy, coord_t cz, logic [RADIN_W-1:0] rad,
			coord_t lo, coord_t hi, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		{origin_x, origin_y, origin_z} <= {ox, oy, oz};
		{direction_x, direction_y, direction_z} <= {dx, dy, dz};
		{center_x, center_y, center_z} <= {cx, cy, cz};
		sphere_radius <= rad;
		interval_low <= lo;
		interval_high <= hi;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// a ray aimed near a random sphere with random content and random intervals
	task automatic send_aimed(int gap);
		coord_t ox, oy, oz, cx, cy, cz;
		ox = rand_small(200);
		oy = rand_small(200);
		oz = rand_small(200);
		cx = rand_small(200) + coord_t'($urandom_range(65535));
		cy = rand_small(200);
		cz = rand_small(200);
		send_word(ox, oy, oz,
			(cx - ox + rand_small(20)) >>> $urandom_range(4),
			(cy - oy + rand_small(20)) >>> $urandom_range(4),
			(cz - oz + rand_small(20)) >>> $urandom_range(4),
			cx, cy, cz, RADIN_W'($urandom_range(64 << 16)),
			($urandom_range(3) == 0) ? rand_word() : rand_small(4),
			($urandom_range(3) == 0) ? rand_word() : rand_small(40), gap);
	endtask

	initial begin
		coord_t mx, mn;
		int gap;
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		arst_n = 1'b0;
		start = 1'b0;
		{origin_x, origin_y, origin_z} = '0;
		{direction_x, direction_y, direction_z} = '0;
		{center_x, center_y, center_z} = '0;
		sphere_radius = '0;
		interval_low = '0;
		interval_high = '0;
		quiet_cycles = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// plain hit from outside, then from inside the sphere
		send_word(0, 0, 0, 1 << 16, 0, 0, 10 << 16, 0, 0, 2 << 16, 0, mx, 0);
		send_word(10 << 16, 0, 0, 1 << 16, 0, 0, 10 << 16, 0, 0, 2 << 16, 0, mx, 0);
		// zero direction
		send_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 1 << 16, mn, mx, 0);
		// negative discriminant
		send_word(0, 5 << 16, 0, 1 << 16, 0, 0, 10 << 16, 0, 0, 1 << 16, mn, mx, 0);
		// tangent ray
		send_word(0, 2 << 16, 0, 1 << 16, 0, 0, 10 << 16, 0, 0, 2 << 16, mn, mx, 0);
		// empty and inverted intervals
		send_word(0, 0, 0, 1 << 16, 0, 0, 10 << 16, 0, 0, 2 << 16, 5 << 16, 5 << 16, 1);
		send_word(0, 0, 0, 1 << 16, 0, 0, 10 << 16, 0, 0, 2 << 16, mx, mn, 0);
		// only the far root inside, neither inside
		send_word(0, 0, 0, 1 << 16, 0, 0, 10 << 16, 0, 0, 2 << 16, 9 << 16, mx, 2);
		send_word(0, 0, 0, 1 << 16, 0, 0, 10 << 16, 0, 0, 2 << 16, 13 << 16, mx, 0);
		// negative t and reverse ray
		send_word(0, 0, 0, -(1 << 16), 0, 0, 10 << 16, 0, 0, 2 << 16, mn, mx, 0);
		// saturating t: tiny direction, far sphere
		send_word(0, 0, 0, 1, 0, 0, mx, 0, 0, 1 << 16, mn, mx, 0);
		send_word(mx, mx, mx, 1, 1, 1, mn, mn, mn, {RADIN_W{1'b1}}, mn, mx, 0);
		// extremes of every field
		send_word(mn, mn, mn, mn, mn, mn, mx, mx, mx, {RADIN_W{1'b1}}, mn, mx, 0);
		send_word(mx, mx, mx, mx, mx, mx, mn, mn, mn, {RADIN_W{1'b1}}, mn, mx, 3);
		send_word(mn, mx, mn, mx, mn, mx, mn, mx, mn, '0, mn, mx, 0);
		send_word(-1, -1, -1, -1, -1, -1, 0, 0, 0, '0, mn, mx, 0);
		send_word(0, 0, 0, mn, 0, 0, 0, 0, 0, {RADIN_W{1'b1}}, mn, mx, 0);
		send_word(0, 0, 0, 1, 1, 1, 0, 0, 0, 1, -1, 1, 0);

		for (int i = 0; i < N_RANDOM; i++) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
			if ((i / 100) % 3 == 1)
				gap = 0;
			if ($urandom_range(9) < 7)
				send_aimed(gap);
			else
				send_word(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
					rand_word(), rand_word(), rand_word(), rand_word(),
					RADIN_W'($urandom), rand_word(), rand_word(), gap);
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_mul.sv
hw/rtl/rsi_sqrt.sv
hw/rtl/rsi_div.sv
hw/rtl/ray_sphere_intersection.sv
tb/ray_sphere_intersection_checker.sv
tb/ray_sphere_intersection_tb.sv
